@@ hdl/monochrome_page_framebuffer_unit_defines.svh @@
// Assertion macros for the page-mode frame store.
// Taken in by the controller and the datapath; expects clk and arst_n in scope.
`ifndef MONOCHROME_PAGE_FRAMEBUFFER_UNIT_DEFINES_SVH
`define MONOCHROME_PAGE_FRAMEBUFFER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define MPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPF_ASSERT(lbl, prop, msg)
`define MPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/mpfb_pkg.sv @@
// Shared types, codes and byte functions for the page-mode frame store.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package mpfb_pkg;

	localparam int PANEL_WIDTH_DEF  = 128;
	localparam int PANEL_HEIGHT_DEF = 64;

	localparam logic [6:0] COL_OFFSET_RESET = 7'd2;
	localparam logic [7:0] PAGE_CMD_BASE    = 8'hB0;
	localparam logic [7:0] COL_HIGH_CMD     = 8'h10;
	localparam logic [7:0] BYTE_ONES        = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS       = 8'h00;

	localparam logic [1:0] PEN_ERASE  = 2'd0;
	localparam logic [1:0] PEN_SET    = 2'd1;
	localparam logic [1:0] PEN_INVERT = 2'd2;

	typedef enum logic [1:0] {
		CMD_DRAW = 2'd0,
		CMD_FILL = 2'd1,
		CMD_SEND = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_FILL,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic take_draw;
		logic take_fill;
		logic take_send;
		logic draw_wr;
		logic sweep_run;
		logic send_load;
	} ctl_t;

	typedef struct packed {
		logic sweep_done;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] fill_byte(input logic [1:0] pen, input logic [7:0] d);
		logic [7:0] r;
		case (pen)
			PEN_SET:   r = BYTE_ONES;
			PEN_ERASE: r = BYTE_ZEROS;
			default:   r = ~d;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] draw_byte(input logic [1:0] pen, input logic [7:0] d,
			input logic [2:0] bit_idx);
		logic [7:0] mask;
		logic [7:0] r;
		mask = 8'd1 << bit_idx;
		case (pen)
			PEN_SET:    r = d | mask;
			PEN_INVERT: r = d ^ mask;
			default:    r = d & ~mask;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/mpfb_ctrl.sv @@
// Command sequencer for the page-mode frame store.
// Depends on mpfb_pkg; drives the datapath through ctl_t and reads sts_t.
`timescale 1ns / 1ps
`include "monochrome_page_framebuffer_unit_defines.svh"
module mpfb_ctrl import mpfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] command,
	input  sts_t       sts,
	output ctl_t       ctl
);

	state_t state_q, state_d;
	cmd_t   cmd;
	logic   take;
	logic [2:0] take_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = cmd_t'(command);
		s_tready = (state_q == ST_IDLE) && ((cmd != CMD_SEND) || sts.out_free);
		take     = s_tvalid && s_tready;
		ctl      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (cmd)
						CMD_DRAW: begin
							ctl.take_draw = 1'b1;
							state_d = ST_DRAW;
						end
						CMD_FILL: begin
							ctl.take_fill = 1'b1;
							state_d = ST_FILL;
						end
						CMD_SEND: begin
							ctl.take_send = 1'b1;
							state_d = ST_SEND;
						end
						CMD_NOP: begin
							state_d = ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_DRAW: begin
				ctl.draw_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FILL: begin
				ctl.sweep_run = 1'b1;
				if (sts.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				ctl.send_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign take_vec = {ctl.take_draw, ctl.take_fill, ctl.take_send};

	`MPF_ASSERT(a_one_take, $onehot0(take_vec), "more than one command taken")
	`MPF_ASSERT_NEXT(a_draw_next, ctl.take_draw, state_q == ST_DRAW, "draw not followed by write")
	`MPF_ASSERT_NEXT(a_send_once, state_q == ST_SEND, state_q == ST_IDLE, "send state held")

endmodule

@@ hdl/mpfb_datapath.sv @@
// Frame store memory, upload counters and output register.
// Depends on mpfb_pkg; steered by mpfb_ctrl through ctl_t.
`timescale 1ns / 1ps
`include "monochrome_page_framebuffer_unit_defines.svh"
module mpfb_datapath import mpfb_pkg::*; #(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic signed [7:0] pos_x,
	input  logic signed [7:0] pos_y,
	input  logic [1:0]        pen,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata,
	input  ctl_t              ctl,
	output sts_t              sts,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
	localparam int DEPTH      = PAGE_COUNT * PANEL_WIDTH;
	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int PAGE_LEN   = PANEL_WIDTH + 3;
	localparam int SW         = $clog2(PAGE_LEN);

	localparam logic [7:0]    WIDTH_LIM  = 8'(PANEL_WIDTH);
	localparam logic [7:0]    HEIGHT_LIM = 8'(PANEL_HEIGHT);
	localparam logic [SW-1:0] SLOT_PAGE  = SW'(0);
	localparam logic [SW-1:0] SLOT_HIGH  = SW'(1);
	localparam logic [SW-1:0] SLOT_LOW   = SW'(2);
	localparam logic [SW-1:0] SLOT_DATA  = SW'(3);
	localparam logic [SW-1:0] SLOT_LAST  = SW'(PAGE_LEN - 1);
	localparam logic [PW-1:0] PAGE_LAST  = PW'(PAGE_COUNT - 1);
	localparam logic [CW-1:0] SWEEP_END  = CW'(DEPTH);

	logic [7:0]    mem_q [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	logic [6:0]    col_off_q;
	logic [CW-1:0] sweep_cnt_q;
	logic [1:0]    fill_pen_q;

	logic          pix_ok;
	logic [PW-1:0] pix_page;
	logic [AW-1:0] pix_addr;
	logic          pix_ok_q;
	logic [AW-1:0] pix_addr_q;
	logic [2:0]    pix_bit_q;
	logic [1:0]    pen_q;

	logic [PW-1:0] page_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] up_col;
	logic [AW-1:0] up_addr;
	logic          last_slot;
	logic          last_page;
	logic [7:0]    byte_s1;
	logic          is_data_s1;
	logic          last_s1;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          is_data_q;
	logic          frame_end_q;

	// pixel address and range check
	assign pix_ok   = !pos_x[7] && !pos_y[7] && ({1'b0, pos_x[6:0]} < WIDTH_LIM)
		&& ({1'b0, pos_y[6:0]} < HEIGHT_LIM);
	assign pix_page = pos_y[PW+2:3];
	assign pix_addr = AW'(AW'(pix_page) * AW'(PANEL_WIDTH) + AW'(pos_x[6:0]));

	// upload byte position
	assign up_col    = slot_q - SLOT_DATA;
	assign up_addr   = AW'(AW'(page_q) * AW'(PANEL_WIDTH) + AW'(up_col));
	assign last_slot = (slot_q == SLOT_LAST);
	assign last_page = (page_q == PAGE_LAST);

	always_comb begin
		if (ctl.sweep_run) begin
			rd_addr = sweep_cnt_q[AW-1:0];
		end else if (ctl.take_draw) begin
			rd_addr = pix_addr;
		end else begin
			rd_addr = up_addr;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pix_addr_q;
		wr_data = draw_byte(pen_q, rdata_q, pix_bit_q);
		if (ctl.sweep_run && (sweep_cnt_q != '0)) begin
			wr_en   = 1'b1;
			wr_addr = AW'(sweep_cnt_q - CW'(1));
			wr_data = fill_byte(fill_pen_q, rdata_q);
		end else if (ctl.draw_wr && pix_ok_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_off_q <= COL_OFFSET_RESET;
		end else if (cfg_we) begin
			col_off_q <= cfg_wdata;
		end
	end

	// sweep starts at reset as a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
			fill_pen_q  <= PEN_ERASE;
		end else if (ctl.take_fill) begin
			sweep_cnt_q <= '0;
			fill_pen_q  <= pen;
		end else if (ctl.sweep_run && (sweep_cnt_q != SWEEP_END)) begin
			sweep_cnt_q <= sweep_cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_draw) begin
			pix_ok_q   <= pix_ok;
			pix_addr_q <= pix_addr;
			pix_bit_q  <= pos_y[2:0];
			pen_q      <= pen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			slot_q <= '0;
		end else if (ctl.take_send) begin
			if (last_slot) begin
				slot_q <= '0;
				page_q <= last_page ? '0 : page_q + PW'(1);
			end else begin
				slot_q <= slot_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_send) begin
			is_data_s1 <= (slot_q >= SLOT_DATA);
			last_s1    <= last_slot && last_page;
			if (slot_q == SLOT_PAGE) begin
				byte_s1 <= PAGE_CMD_BASE + 8'(page_q);
			end else if (slot_q == SLOT_HIGH) begin
				byte_s1 <= COL_HIGH_CMD | {5'b0, col_off_q[6:4]};
			end else if (slot_q == SLOT_LOW) begin
				byte_s1 <= {4'b0, col_off_q[3:0]};
			end else begin
				byte_s1 <= BYTE_ZEROS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.send_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.send_load) begin
			out_byte_q  <= is_data_s1 ? rdata_q : byte_s1;
			is_data_q   <= is_data_s1;
			frame_end_q <= last_s1;
		end
	end

	assign sts.sweep_done = (sweep_cnt_q == SWEEP_END);
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = is_data_q;
	assign m_tlast  = frame_end_q;

	`MPF_ASSERT_NEXT(a_send_free, ctl.take_send, ctl.send_load && sts.out_free, "output word overrun")
	`MPF_ASSERT(a_sweep_range, sweep_cnt_q <= SWEEP_END, "sweep counter out of range")
	`MPF_ASSERT(a_one_writer, !(ctl.draw_wr && ctl.sweep_run), "two store writers at once")

endmodule

@@ hdl/monochrome_page_framebuffer_unit.sv @@
// Top level of the page-mode frame store: controller plus datapath.
// Depends on mpfb_pkg, mpfb_ctrl and mpfb_datapath.
//
// Input stream s_*: one command word per handshake (draw pixel, fill, send next
// upload byte, or an ignored code). Output stream m_*: one upload byte per send
// command, with tuser high for display data and tlast on the final data byte
// of the last page. cfg_we/cfg_wdata write the column offset (reset 2).
// Steps: a draw reads the memory, then does a modify-write of one byte.
// A send reads the memory, then loads the output register, and its word shows
// on m_tvalid once that register is loaded. A fill runs the sweep over the
// whole store: the sweep reads one byte per cycle and writes it back in the
// next cycle through the single write port. An ignored code leaves the
// controller idle.
// Reset: the store is cleared by the same sweep while s_tready stays low; the
// upload position is 0.
// When the receiver stalls, the word waits in the output register; draws and
// fills go on, and a further send is held off until that word is taken.
`timescale 1ns / 1ps
module monochrome_page_framebuffer_unit import mpfb_pkg::*; #(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // command[1:0], pos_x[9:2], pos_y[17:10], pen[19:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tuser,   // is_data[0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	ctl_t ctl;
	sts_t sts;

	mpfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tdata[1:0]),
		.sts      (sts),
		.ctl      (ctl)
	);

	mpfb_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_x     (s_tdata[9:2]),
		.pos_y     (s_tdata[17:10]),
		.pen       (s_tdata[19:18]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
